/* hdl/sfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants for the section filter
// Opcodes, register indexes, result codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int unsigned KEY_TABLE_DEPTH_DEF   = 256;
	localparam int unsigned MAX_SECTION_BYTES_DEF = 4999;

	localparam int unsigned HEADER_LEN      = 7;
	localparam logic [7:0]  TIMEOUT_RESET   = 8'd15;
	localparam logic [15:0] MIN_SECTION_LEN = 16'd14;
	localparam logic [7:0]  SECT_SYNTAX_LO  = 8'h70;
	localparam logic [7:0]  SECT_SYNTAX_HI  = 8'h7f;
	localparam logic [7:0]  SPECIAL_BYTE    = 8'hff;
	localparam logic [12:0] LEN_OVERHEAD    = 13'd3;
	localparam logic [15:0] BYTE_CNT_MAX    = 16'hffff;
	localparam logic [7:0]  IDLE_SEC_MAX    = 8'hff;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2
	} sfd_opcode_t;

	typedef enum logic [1:0] {
		CFG_TABLE_ID = 2'd0,
		CFG_SPECIAL  = 2'd1,
		CFG_TIMEOUT  = 2'd2
	} sfd_cfg_reg_t;

	typedef enum logic [2:0] {
		ST_NEW      = 3'd0,
		ST_DUP      = 3'd1,
		ST_REJECT   = 3'd2,
		ST_TIMEOUT  = 3'd3,
		ST_FINISHED = 3'd4,
		ST_FULL     = 3'd5
	} sfd_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_COMPARE,
		S_EMIT
	} sfd_state_t;

	typedef struct packed {
		logic        take_byte;
		logic        take_tick;
		logic        clear_all;
		logic        clear_bytes;
		logic        set_finish;
		logic        search_start;
		logic        search_next;
		logic        store;
		logic        load_res;
		sfd_status_t status;
	} sfd_cmd_t;

	typedef struct packed {
		logic finished;
		logic timed_out;
		logic rejected;
		logic count_zero;
		logic table_full;
		logic key_match;
		logic idx_last;
	} sfd_stat_t;

endpackage
`default_nettype wire

/* hdl/sfd_item_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_item_if: input item channel
// One section byte, tick or clear per transfer.
// ----------------------------------------------------------------------------
interface sfd_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, opcode, data_byte, last_byte, input ready);
	modport sink   (input valid, opcode, data_byte, last_byte, output ready);
endinterface
`default_nettype wire

/* hdl/sfd_result_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_result_if: result channel
// One verdict per completed section.
// ----------------------------------------------------------------------------
interface sfd_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  slot_index;
	logic [31:0] section_key;
	logic [8:0]  section_count;
	logic        grabbing_done;

	modport source (output valid, status, slot_index, section_key, section_count,
		grabbing_done, input ready);
	modport sink   (input valid, status, slot_index, section_key, section_count,
		grabbing_done, output ready);
endinterface
`default_nettype wire

/* hdl/sfd_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_cfg_if: register write channel
// Register index plus write data per transfer.
// ----------------------------------------------------------------------------
interface sfd_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/sfd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_ctrl: section filter controller
// Sequences intake, end-of-section checks, key search and result hand-off.
// ----------------------------------------------------------------------------
module sfd_ctrl
	import sfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	input  wire logic [1:0] item_opcode,
	input  wire logic       item_last,
	output logic            item_ready,
	output logic            res_valid,
	input  wire logic       res_ready,
	input  wire sfd_stat_t  stat,
	output sfd_cmd_t        cmd
);

	sfd_state_t  state_q, state_d;
	sfd_status_t status_q, status_d;
	logic        res_valid_q;
	logic        item_xfer;

	assign item_ready = (state_q == S_IDLE);
	assign item_xfer  = item_valid && item_ready;
	assign res_valid  = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_REJECT;
			res_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (cmd.load_res)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_xfer && item_opcode == OP_BYTE && item_last)
					state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.finished || stat.timed_out || stat.rejected || stat.count_zero)
					state_d = S_EMIT;
				else
					state_d = S_READ;
			end
			S_READ: state_d = S_COMPARE;
			S_COMPARE: begin
				if (stat.key_match || stat.idx_last)
					state_d = S_EMIT;
				else
					state_d = S_READ;
			end
			S_EMIT: begin
				if (!res_valid_q || res_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd        = '0;
		cmd.status = status_q;
		status_d   = status_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_xfer) begin
					unique case (item_opcode)
						OP_BYTE:  cmd.take_byte = 1'b1;
						OP_TICK:  cmd.take_tick = 1'b1;
						OP_CLEAR: cmd.clear_all = 1'b1;
						default:  ;
					endcase
				end
			end
			S_CHECK: begin
				cmd.clear_bytes = 1'b1;
				if (stat.finished) begin
					status_d = ST_FINISHED;
				end else if (stat.timed_out) begin
					cmd.set_finish = 1'b1;
					status_d       = ST_TIMEOUT;
				end else if (stat.rejected) begin
					status_d = ST_REJECT;
				end else if (stat.count_zero) begin
					cmd.store = 1'b1;
					status_d  = ST_NEW;
				end else begin
					cmd.search_start = 1'b1;
				end
			end
			S_READ: ;
			S_COMPARE: begin
				if (stat.key_match) begin
					status_d = ST_DUP;
				end else if (stat.idx_last) begin
					if (stat.table_full) begin
						status_d = ST_FULL;
					end else begin
						cmd.store = 1'b1;
						status_d  = ST_NEW;
					end
				end else begin
					cmd.search_next = 1'b1;
				end
			end
			S_EMIT: cmd.load_res = !res_valid_q || res_ready;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_check_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> $past(item_xfer && item_opcode == OP_BYTE && item_last))
		else $error("check entered without a final byte");
	a_store_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> !stat.table_full)
		else $error("store into a full key table");
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result raised outside emit");
`endif

endmodule
`default_nettype wire

/* hdl/sfd_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_datapath: section filter datapath
// Header capture, counters, register file, key table memory, result register.
// ----------------------------------------------------------------------------
module sfd_datapath
	import sfd_pkg::*;
#(
	parameter int unsigned KEY_TABLE_DEPTH   = KEY_TABLE_DEPTH_DEF,
	parameter int unsigned MAX_SECTION_BYTES = MAX_SECTION_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic [7:0]  data_byte,
	input  wire sfd_cmd_t    cmd,
	output sfd_stat_t        stat,
	output logic [2:0]       res_status,
	output logic [7:0]       res_slot_index,
	output logic [31:0]      res_section_key,
	output logic [8:0]       res_section_count,
	output logic             res_grabbing_done
);

	localparam int unsigned AW = $clog2(KEY_TABLE_DEPTH);
	localparam int unsigned CW = $clog2(KEY_TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(KEY_TABLE_DEPTH);
	localparam logic [15:0]   MAX_LEN   = 16'(MAX_SECTION_BYTES);

	// registers
	logic [7:0]    table_id_q;
	logic          special_q;
	logic [7:0]    timeout_q;
	logic [15:0]   byte_cnt_q;
	logic [7:0]    idle_q;
	logic          finished_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [7:0]    hdr_q [HEADER_LEN];
	logic [31:0]   key_mem [KEY_TABLE_DEPTH];
	logic [31:0]   rd_q;

	logic [31:0]   key_w;
	logic [12:0]   sec_len_w;
	logic [15:0]   sec_len_ext;
	logic [AW-1:0] slot_w;
	logic [AW+7:0] slot_ext;
	logic [CW+8:0] cnt_ext;
	logic          key_valid_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_id_q <= '0;
			special_q  <= 1'b0;
			timeout_q  <= TIMEOUT_RESET;
			byte_cnt_q <= '0;
			idle_q     <= '0;
			finished_q <= 1'b0;
			count_q    <= '0;
			idx_q      <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_TABLE_ID: table_id_q <= cfg_data;
					CFG_SPECIAL:  special_q  <= cfg_data[0];
					CFG_TIMEOUT:  timeout_q  <= cfg_data;
					default:      ;
				endcase
			end
			if (cmd.clear_all || cmd.clear_bytes)
				byte_cnt_q <= '0;
			else if (cmd.take_byte && byte_cnt_q != BYTE_CNT_MAX)
				byte_cnt_q <= byte_cnt_q + 16'd1;
			if (cmd.clear_all || cmd.store)
				idle_q <= '0;
			else if (cmd.take_tick && idle_q != IDLE_SEC_MAX)
				idle_q <= idle_q + 8'd1;
			if (cmd.clear_all)
				finished_q <= 1'b0;
			else if (cmd.set_finish)
				finished_q <= 1'b1;
			if (cmd.clear_all)
				count_q <= '0;
			else if (cmd.store)
				count_q <= count_q + CW'(1);
			if (cmd.search_start)
				idx_q <= '0;
			else if (cmd.search_next)
				idx_q <= idx_q + AW'(1);
		end
	end

	// header capture, key table and result payload
	always_ff @(posedge clk) begin
		if (cmd.take_byte && byte_cnt_q < 16'(HEADER_LEN))
			hdr_q[byte_cnt_q[2:0]] <= data_byte;
		if (cmd.store)
			key_mem[count_q[AW-1:0]] <= key_w;
		rd_q <= key_mem[idx_q];
		if (cmd.load_res) begin
			res_status        <= cmd.status;
			res_slot_index    <= (cmd.status == ST_NEW) ? slot_ext[7:0] : 8'd0;
			res_section_key   <= key_valid_w ? key_w : 32'd0;
			res_section_count <= cnt_ext[8:0];
			res_grabbing_done <= finished_q;
		end
	end

	assign key_w       = {hdr_q[5], hdr_q[6], hdr_q[3], hdr_q[4]};
	assign sec_len_w   = {1'b0, hdr_q[1][3:0], hdr_q[2]} + LEN_OVERHEAD;
	assign sec_len_ext = {3'd0, sec_len_w};
	assign slot_w      = count_q[AW-1:0] - AW'(1);
	assign slot_ext    = {8'd0, slot_w};
	assign cnt_ext     = {9'd0, count_q};
	assign key_valid_w = (cmd.status == ST_NEW) || (cmd.status == ST_DUP) ||
		(cmd.status == ST_FULL);

	always_comb begin
		stat.finished   = finished_q;
		stat.timed_out  = idle_q > timeout_q;
		stat.rejected   = (byte_cnt_q < MIN_SECTION_LEN) || (hdr_q[0] != table_id_q) ||
			(hdr_q[1] < SECT_SYNTAX_LO) || (hdr_q[1] > SECT_SYNTAX_HI) ||
			(sec_len_ext > byte_cnt_q) || (sec_len_ext > MAX_LEN) ||
			(special_q && hdr_q[3] == SPECIAL_BYTE);
		stat.count_zero = (count_q == '0);
		stat.table_full = (count_q == DEPTH_CNT);
		stat.key_match  = (rd_q == key_w);
		stat.idx_last   = (CW'(idx_q) + CW'(1)) == count_q;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("stored count beyond table depth");
	a_search_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.search_next |-> (CW'(idx_q) + CW'(1)) < count_q)
		else $error("search past the stored keys");
`endif

endmodule
`default_nettype wire

/* hdl/section_filter_dedup.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// section_filter_dedup: table section filter with key deduplication
// Checks each received section, dedups it by a 32-bit key against a table
// of stored keys and reports one verdict per section.
// ----------------------------------------------------------------------------
//
// channel   dir   payload                                        handshake
// item      in    opcode, data_byte, last_byte                   valid/ready
// result    out   status, slot_index, section_key,               valid/ready
//                 section_count, grabbing_done
// cfg       in    index, data                                    valid/ready
//
// Bytes that are not last, ticks and clears are taken in the idle state; a
// transfer can follow every cycle while the controller is idle.
// A final byte goes through check, then a read/compare pair per stored key
// compared before a match or the end of the table, then emit, which waits
// while the result register is full; the key memory read is registered.
// Reset (arst_n low) clears counters, timer, finish flag and registers to
// their defaults; the key table needs no clearing since only entries below
// the stored count are ever searched.
// A waiting result holds in the output register; intake of the next item goes
// on until another verdict must be loaded while the register is still full.
// ----------------------------------------------------------------------------
module section_filter_dedup
	import sfd_pkg::*;
#(
	parameter int unsigned KEY_TABLE_DEPTH   = KEY_TABLE_DEPTH_DEF,
	parameter int unsigned MAX_SECTION_BYTES = MAX_SECTION_BYTES_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sfd_item_if.sink    item,
	sfd_result_if.source result,
	sfd_cfg_if.sink     cfg
);

	sfd_cmd_t  cmd;
	sfd_stat_t stat;

	// registers can be written any cycle
	assign cfg.ready = 1'b1;

	// control: handshakes, verdict sequencing
	sfd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_opcode (item.opcode),
		.item_last   (item.last_byte),
		.item_ready  (item.ready),
		.res_valid   (result.valid),
		.res_ready   (result.ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	// datapath: header, counters, key table, result register
	sfd_datapath #(
		.KEY_TABLE_DEPTH   (KEY_TABLE_DEPTH),
		.MAX_SECTION_BYTES (MAX_SECTION_BYTES)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg.valid),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.data_byte         (item.data_byte),
		.cmd               (cmd),
		.stat              (stat),
		.res_status        (result.status),
		.res_slot_index    (result.slot_index),
		.res_section_key   (result.section_key),
		.res_section_count (result.section_count),
		.res_grabbing_done (result.grabbing_done)
	);

endmodule
`default_nettype wire

/* tb/tb_section_filter_dedup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_section_filter_dedup: self-checking bench for the section filter
// Drives section bytes, ticks and clears with random gaps, stalls the verdict
// side at random, and checks every verdict against a built-in predictor of
// the header checks, the key table and the idle timeout.
// ----------------------------------------------------------------------------
module tb_section_filter_dedup;
	import sfd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int unsigned LONG_HOLD   = 2000;      // verdict side hold-off
	localparam int unsigned TAIL_CYCLES = 600;       // > worst key search
	localparam logic [1:0]  OP_UNUSED   = 2'd3;      // ignored by the block

	// fixed keys for the directed part; byte 3 of the section is key[15:8]
	localparam logic [31:0] KEY_A  = 32'h1234_5678;
	localparam logic [31:0] KEY_B  = 32'h00ff_0000;
	localparam logic [31:0] KEY_C  = 32'hffff_ffff;
	localparam logic [31:0] KEY_FF = 32'ha5c3_ff01;

	// one verdict as seen on the result channel
	typedef struct packed {
		sfd_status_t status;
		logic [7:0]  slot;
		logic [31:0] key;
		logic [8:0]  count;
		logic        done;
	} verdict_t;

	// Predictor: mirrors header capture, checks, key table and idle timer.
	// note_item() is called per accepted input transfer, check_verdict()
	// per accepted result transfer.
	class section_tracker;
		logic [7:0]  hdr [HEADER_LEN];
		logic [15:0] byte_cnt;
		logic [31:0] keys [KEY_TABLE_DEPTH_DEF];
		int unsigned stored;
		logic [7:0]  idle_sec;
		bit          finished;
		logic [7:0]  want_tid;
		bit          special;
		logic [7:0]  timeout_sec;
		verdict_t    pending_verdicts [$];
		int unsigned errors;

		function new();
			foreach (hdr[i]) hdr[i] = '0;
			byte_cnt    = '0;
			stored      = 0;
			idle_sec    = '0;
			finished    = 1'b0;
			want_tid    = '0;
			special     = 1'b0;
			timeout_sec = TIMEOUT_RESET;
			errors      = 0;
		endfunction

		function void write_reg(sfd_cfg_reg_t idx, logic [7:0] value);
			case (idx)
				CFG_TABLE_ID: want_tid = value;
				CFG_SPECIAL:  special = value[0];
				CFG_TIMEOUT:  timeout_sec = value;
				default: ;
			endcase
		endfunction

		function void note_item(logic [1:0] op, logic [7:0] data, logic last);
			verdict_t    v;
			int unsigned decl_len;
			logic [31:0] key;
			bit          hit;
			case (op)
				OP_TICK: begin
					if (idle_sec != IDLE_SEC_MAX) idle_sec++;
				end
				OP_CLEAR: begin
					// empties the table and drops any partial section
					stored   = 0;
					idle_sec = '0;
					finished = 1'b0;
					byte_cnt = '0;
				end
				OP_BYTE: begin
					if (byte_cnt < HEADER_LEN) hdr[byte_cnt] = data;
					if (byte_cnt != BYTE_CNT_MAX) byte_cnt++;
					if (last) begin
						v = '{status: ST_REJECT, slot: '0, key: '0, count: '0, done: 1'b0};
						if (finished) begin
							v.status = ST_FINISHED;
						end else if (idle_sec > timeout_sec) begin
							finished = 1'b1;
							v.status = ST_TIMEOUT;
						end else if (byte_cnt >= MIN_SECTION_LEN && hdr[0] == want_tid &&
							hdr[1] >= SECT_SYNTAX_LO && hdr[1] <= SECT_SYNTAX_HI) begin
							decl_len = {hdr[1][3:0], hdr[2]} + LEN_OVERHEAD;
							if (decl_len <= byte_cnt && decl_len <= MAX_SECTION_BYTES_DEF &&
								!(special && hdr[3] == SPECIAL_BYTE)) begin
								key = {hdr[5], hdr[6], hdr[3], hdr[4]};
								hit = 1'b0;
								for (int i = 0; i < stored; i++)
									if (keys[i] == key) hit = 1'b1;
								v.key = key;
								if (hit) begin
									v.status = ST_DUP;
								end else if (stored >= KEY_TABLE_DEPTH_DEF) begin
									v.status = ST_FULL;
								end else begin
									keys[stored] = key;
									v.slot       = 8'(stored);
									stored++;
									idle_sec     = '0;
									v.status     = ST_NEW;
								end
							end
						end
						v.count = 9'(stored);
						v.done  = finished;
						pending_verdicts.insert(pending_verdicts.size(), v);
						byte_cnt = '0;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_verdict(verdict_t got);
			verdict_t want;
			if (pending_verdicts.size() == 0) begin
				errors++;
				$display("%0t: verdict with none expected: status %0d slot %0d key %h",
					$time, got.status, got.slot, got.key);
				return;
			end
			want = pending_verdicts.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: verdict mismatch: expected status %0d slot %0d key %h count %0d done %0b",
					$time, want.status, want.slot, want.key, want.count, want.done);
				$display("%0t:                     actual status %0d slot %0d key %h count %0d done %0b",
					$time, got.status, got.slot, got.key, got.count, got.done);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sfd_item_if   item_ch();
	sfd_result_if res_ch();
	sfd_cfg_if    cfg_ch();

	section_filter_dedup u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	section_tracker tracker;

	int unsigned items_sent;     // counts transfers the block acts on
	int unsigned results_seen;
	int unsigned cycle_count;
	bit          tx_gaps;        // cleared for the very long section
	bit          tx_steady;      // stretch with no sender gaps
	int unsigned tx_mode_left;
	logic [7:0]  cur_tid;        // table id the sender aims at

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: the only way a missing verdict ends the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_section_filter_dedup: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------

	// One input transfer. Valid stays high into the next call when no gap is
	// drawn, so back-to-back items never lower and raise valid in one step.
	task automatic send_item(input logic [1:0] op, input logic [7:0] data, input logic last);
		int unsigned gap;
		int unsigned r;
		item_ch.valid     <= 1'b1;
		item_ch.opcode    <= op;
		item_ch.data_byte <= data;
		item_ch.last_byte <= last;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		tracker.note_item(op, data, last);
		if (op != OP_UNUSED) items_sent++;
		// alternate between steady stretches and gappy ones
		if (tx_mode_left == 0) begin
			tx_steady    = ($urandom_range(0, 3) == 0);
			tx_mode_left = $urandom_range(30, 300);
		end
		tx_mode_left--;
		r = $urandom_range(0, 99);
		if (!tx_gaps || tx_steady || r < 55) gap = 0;
		else if (r < 90) gap = $urandom_range(1, 3);
		else if (r < 98) gap = $urandom_range(4, 12);
		else gap = $urandom_range(20, 80);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Section with an explicit header; bytes 3..6 carry the key, the tail is
	// random filler.
	task automatic send_section(input logic [7:0] tid, input logic [7:0] b1,
		input logic [7:0] b2, input logic [31:0] key, input int unsigned total);
		logic [7:0] d;
		for (int unsigned n = 0; n < total; n++) begin
			case (n)
				0: d = tid;
				1: d = b1;
				2: d = b2;
				3: d = key[15:8];
				4: d = key[7:0];
				5: d = key[31:24];
				6: d = key[23:16];
				default: d = 8'($urandom);
			endcase
			send_item(OP_BYTE, d, n == total - 1);
		end
	endtask

	// Well-formed section: declared length matches what is sent (capped at
	// the 12-bit field for oversized ones).
	task automatic send_good(input logic [7:0] tid, input logic [31:0] key,
		input int unsigned total);
		int unsigned decl;
		decl = (total - 3 > 32'h0fff) ? 32'h0fff : total - 3;
		send_section(tid, SECT_SYNTAX_LO | 8'(decl[11:8]), 8'(decl[7:0]), key, total);
	endtask

	// Park the sender until every verdict is in, then let the items behind the
	// last verdict settle. settle must be at least 1.
	task automatic wait_idle(input int unsigned settle);
		item_ch.valid <= 1'b0;
		while (tracker.pending_verdicts.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input sfd_cfg_reg_t idx, input logic [7:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		tracker.write_reg(idx, value);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// upper bits of the special-mode write are junk on purpose
	task automatic configure(input logic [7:0] tid, input logic special,
		input logic [7:0] timeout_s);
		write_reg(CFG_TABLE_ID, tid);
		write_reg(CFG_SPECIAL, {7'($urandom), special});
		write_reg(CFG_TIMEOUT, timeout_s);
		cur_tid = tid;
	endtask

	// Mostly well-formed sections drawing keys from a small pool (so dups are
	// common), plus ticks, clears, broken headers, short declared lengths,
	// stray bytes and the unused opcode.
	task automatic random_traffic(input int unsigned n_items);
		logic [31:0] pool [16];
		logic [31:0] key;
		int unsigned start_items;
		int unsigned r;
		int unsigned total;
		int unsigned decl;
		start_items = items_sent;
		foreach (pool[i]) begin
			pool[i] = $urandom;
			if (i < 3) pool[i][15:8] = SPECIAL_BYTE;   // trips special mode
		end
		while (items_sent - start_items < n_items) begin
			r     = $urandom_range(0, 99);
			key   = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 15)] : $urandom;
			total = ($urandom_range(0, 19) != 0) ? $urandom_range(14, 24) :
				$urandom_range(25, 300);
			decl  = ($urandom_range(0, 3) != 0) ? total - 3 : $urandom_range(11, total - 3);
			if (r < 70) begin
				send_section(cur_tid, SECT_SYNTAX_LO | 8'(decl[11:8]), 8'(decl[7:0]), key, total);
			end else if (r < 78) begin
				repeat ($urandom_range(1, 3)) send_item(OP_TICK, 8'($urandom), 1'($urandom));
			end else if (r < 80) begin
				send_item(OP_CLEAR, 8'($urandom), 1'($urandom));
			end else if (r < 86) begin
				// garbage header, any length
				send_section($urandom_range(0, 1) ? cur_tid : 8'($urandom), 8'($urandom),
					8'($urandom), key, $urandom_range(1, 30));
			end else if (r < 90) begin
				// declared length one byte longer than what arrives
				decl = $urandom_range(12, 40);
				send_section(cur_tid, SECT_SYNTAX_LO, 8'(decl), key, decl + 2);
			end else if (r < 95) begin
				send_item(OP_UNUSED, 8'($urandom), 1'($urandom));
			end else if (r < 99) begin
				// stray byte, merges into the next section
				send_item(OP_BYTE, 8'($urandom), 1'b0);
			end else begin
				wait_idle(1);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Verdict side: random ready with steady stretches, short and long stalls,
	// and one long hold-off so the output register fills and the block stalls
	// its input while the sender keeps offering.
	// ------------------------------------------------------------------------
	initial begin
		verdict_t    got;
		int unsigned stall;
		int unsigned hold_left;
		int unsigned mode_left;
		bit          steady;
		bit          held;
		stall     = 0;
		hold_left = 0;
		mode_left = 0;
		steady    = 1'b0;
		held      = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) continue;
			if (res_ch.valid && res_ch.ready) begin
				got.status = sfd_status_t'(res_ch.status);
				got.slot   = res_ch.slot_index;
				got.key    = res_ch.section_key;
				got.count  = res_ch.section_count;
				got.done   = res_ch.grabbing_done;
				tracker.check_verdict(got);
				results_seen++;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (!held && results_seen >= 30) begin
				held      = 1'b1;
				hold_left = LONG_HOLD;
				res_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					steady    = ($urandom_range(0, 3) == 0);
					mode_left = $urandom_range(50, 400);
				end
				mode_left--;
				if (steady) begin
					res_ch.ready <= 1'b1;
				end else if (stall != 0) begin
					stall--;
					res_ch.ready <= 1'b0;
				end else if ($urandom_range(0, 99) < 25) begin
					stall = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 3) :
						$urandom_range(10, 60);
					res_ch.ready <= 1'b0;
				end else begin
					res_ch.ready <= 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [31:0] first_key;
		tracker      = new();
		items_sent   = 0;
		results_seen = 0;
		cycle_count  = 0;
		tx_gaps      = 1'b1;
		tx_steady    = 1'b0;
		tx_mode_left = 0;
		cur_tid      = '0;
		arst_n       = 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.opcode    <= OP_BYTE;
		item_ch.data_byte <= '0;
		item_ch.last_byte <= 1'b0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= CFG_TABLE_ID;
		cfg_ch.data       <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, phase 1: table id 0, special mode on, no timeout ---
		configure(8'h00, 1'b1, 8'hff);
		send_item(OP_BYTE, 8'hff, 1'b1);                         // one-byte section
		send_good(8'h00, KEY_A, 14);                             // new, slot 0
		send_good(8'h00, KEY_A, 20);                             // duplicate
		send_good(8'h00, KEY_FF, 14);                            // byte 3 = ff, special
		send_section(8'h00, 8'h6f, 8'h0b, KEY_B, 14);            // syntax byte too low
		send_section(8'h00, 8'h80, 8'h0b, KEY_B, 14);            // syntax byte too high
		send_section(8'h01, SECT_SYNTAX_LO, 8'h0b, KEY_B, 14);   // wrong table id
		send_section(8'h00, SECT_SYNTAX_LO, 8'h0c, KEY_B, 14);   // declared one too long
		send_section(8'h00, SECT_SYNTAX_HI, 8'hff, KEY_B, 20);   // max declared length
		send_section(8'h00, SECT_SYNTAX_LO, 8'h0a, KEY_B, 13);   // 13 bytes, too short
		send_item(OP_UNUSED, 8'h5a, 1'b1);                       // ignored opcode
		// idle timer saturates; timeout 255 never fires
		repeat (300) send_item(OP_TICK, 8'($urandom), 1'($urandom));
		send_good(8'h00, KEY_B, 14);
		// byte counter saturation: just over 64K bytes, sent without gaps
		tx_gaps = 1'b0;
		send_good(8'h00, KEY_C, 65537);
		tx_gaps = 1'b1;
		// clear drops a partial section and restarts slot numbering
		repeat (5) send_item(OP_BYTE, 8'($urandom), 1'b0);
		send_item(OP_CLEAR, 8'h00, 1'b0);
		send_good(8'h00, KEY_A, 14);
		wait_idle(16);

		// --- directed, phase 2: table id ff, special off, timeout 0 ---
		configure(8'hff, 1'b0, 8'h00);
		send_good(8'hff, KEY_FF, 14);                            // byte 3 = ff passes now
		send_item(OP_TICK, 8'h00, 1'b0);
		send_good(8'hff, KEY_B, 14);                             // idle 1 > 0: timed out
		send_good(8'hff, KEY_C, 14);                             // already finished
		send_item(OP_BYTE, 8'h00, 1'b1);                         // finished wins over reject
		send_item(OP_CLEAR, 8'hff, 1'b1);
		send_good(8'hff, KEY_B, 14);                             // grabbing again
		wait_idle(16);

		// --- fill the key table, overflow it, then a dup while full ---
		configure(8'($urandom), 1'b0, TIMEOUT_RESET);
		send_item(OP_CLEAR, 8'($urandom), 1'($urandom));
		first_key = {8'h00, 24'($urandom)};
		send_good(cur_tid, first_key, 14);
		// top byte differs for every entry that fits the table, so stored keys are distinct
		for (int n = 1; n < KEY_TABLE_DEPTH_DEF + 3; n++)
			send_good(cur_tid, {8'(n), 24'($urandom)}, 14);
		send_good(cur_tid, first_key, 14);
		send_item(OP_CLEAR, 8'($urandom), 1'($urandom));
		send_good(cur_tid, first_key, 14);
		wait_idle(16);

		// --- random traffic under several register settings ---
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: configure(8'($urandom), 1'b1, 8'd3);
				1: configure(8'hff, 1'b0, 8'hff);
				2: configure(8'h00, 1'($urandom), 8'($urandom_range(0, 20)));
				default: configure(8'($urandom), 1'($urandom), 8'($urandom));
			endcase
			random_traffic(250);
			wait_idle(16);
		end

		wait_idle(TAIL_CYCLES);
		if (tracker.errors == 0) begin
			$display("tb_section_filter_dedup: clean");
		end else begin
			$display("tb_section_filter_dedup: errors");
		end
		$finish;
	end

endmodule
